[design/fcc_pkg.sv]
// Shared constants and types of the full cross-correlation block.
package fcc_pkg;

	localparam int MAX_TAPS     = 32;
	localparam int SAMPLE_WIDTH = 16;
	localparam int VALUE_WIDTH  = 37;
	localparam int PROD_W       = 2 * SAMPLE_WIDTH;
	localparam int TCNT_W       = $clog2(MAX_TAPS + 1);
	localparam int IDX_W        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	typedef struct packed {
		logic clr;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          final_res;
	} res_t;

endpackage

[design/fcc_cell.sv]
// One tap cell of the systolic correlator: tap register, multiply-add, partial-sum register.
module fcc_cell (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         tap_we,
	input  logic signed [fcc_pkg::SAMPLE_WIDTH-1:0]      tap_d,
	input  logic signed [fcc_pkg::SAMPLE_WIDTH-1:0]      x,
	input  fcc_pkg::cell_ctl_t                           ctl,
	input  logic signed [fcc_pkg::VALUE_WIDTH-1:0]       part_in,
	output logic signed [fcc_pkg::VALUE_WIDTH-1:0]       sum,
	output logic signed [fcc_pkg::VALUE_WIDTH-1:0]       part_q
);
	import fcc_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] tap_q;
	logic signed [PROD_W-1:0]       prod;

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_q <= tap_d;
		end
	end

	assign prod = x * tap_q;
	// sum wraps modulo 2^VALUE_WIDTH
	assign sum  = VALUE_WIDTH'(prod) + part_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
		end else if (ctl.clr) begin
			part_q <= '0;
		end else if (ctl.shift) begin
			part_q <= sum;
		end
	end

endmodule

[design/fcc_obuf.sv]
// Two-entry result queue between the cell row and the output channel.
module fcc_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcc_pkg::res_t push_data,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output fcc_pkg::res_t out_data
);
	import fcc_pkg::*;

	logic [1:0] cnt_q;
	res_t       e0_q;
	res_t       e1_q;
	logic       pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = e0_q;

	always_ff @(posedge clk) begin
		if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			e0_q <= push_data;
		end else if (pop) begin
			e0_q <= e1_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			e1_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 2'd1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 2'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

[design/full_cross_correlation.sv]
// Full cross-correlation engine: top level with the cell row, load/flush control and result queue.
//
// Reference beats (func=0) load taps y[0..m-1] in order, one per cycle while in_ready is
// high; the beat with last=1 closes the reference, and taps beyond MAX_TAPS are dropped.
// Data beats (func=1) are taken one per cycle while in_ready is high and each gives one
// result, r = sum_j x[i-j]*y[m-1-j], exact and two's complement, that is pushed into the
// result queue when the beat is accepted. The row is a transposed (systolic) filter: cell k
// holds y[k], every cell multiplies the newest sample and adds the partial sum handed on by
// cell k-1, and the result is read at cell m-1. A data beat with last=1 makes the block
// drain m-1 more results, one per cycle while the queue has room, as zeros are pushed
// through the row; in_ready stays low until the drain is done, so a sequence of n samples
// gives n+m-1 results. The last result of a sequence carries final_res=1, and the partial
// sums are cleared after it and on every reference beat. With no reference loaded every
// result is zero. A two-entry queue sits before the output, so input beats keep flowing
// while one result waits on out_ready; in_ready drops when the queue is full or a drain runs.
module full_cross_correlation (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    func,
	input  logic signed [fcc_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                    last,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [fcc_pkg::VALUE_WIDTH-1:0]  value,
	output logic                                    final_res
);
	import fcc_pkg::*;

	// reference and flush bookkeeping
	logic [TCNT_W-1:0] tap_count_q;
	logic [TCNT_W-1:0] load_pos_q;
	logic [IDX_W-1:0]  flush_cnt_q;   // flush results still owed

	logic              space;
	logic              flushing;
	logic              acc;
	logic              ref_acc;
	logic              dat_acc;
	logic              flush_step;
	logic              last_res;
	logic              room;
	logic [IDX_W-1:0]  sel;
	cell_ctl_t         ctl;
	res_t              res;
	res_t              out_data;

	logic signed [SAMPLE_WIDTH-1:0] x;
	logic signed [VALUE_WIDTH-1:0]  sum_a  [MAX_TAPS];
	logic signed [VALUE_WIDTH-1:0]  part_a [MAX_TAPS];
	logic [MAX_TAPS-1:0]            tap_we;

	assign flushing   = (flush_cnt_q != '0);
	assign in_ready   = space && !flushing;
	assign acc        = in_valid && in_ready;
	assign ref_acc    = acc && !func;
	assign dat_acc    = acc && func;
	assign flush_step = flushing && space;
	assign room       = (load_pos_q < TCNT_W'(MAX_TAPS));

	// last lag of a sequence: the last data beat when at most one tap is loaded, or the final flush step
	assign last_res = (dat_acc && last && (tap_count_q <= TCNT_W'(1))) ||
	                  (flush_step && (flush_cnt_q == IDX_W'(1)));

	assign ctl.clr   = ref_acc || last_res;
	assign ctl.shift = dat_acc || flush_step;

	// zeros go in while flushing
	assign x   = flushing ? '0 : sample;
	assign sel = IDX_W'(tap_count_q - TCNT_W'(1));

	assign res.value     = (tap_count_q == '0) ? '0 : sum_a[sel];
	assign res.final_res = last_res;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		assign tap_we[k] = ref_acc && room && (load_pos_q[IDX_W-1:0] == IDX_W'(k));

		if (k == 0) begin : g_head
			fcc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tap_we  (tap_we[k]),
				.tap_d   (sample),
				.x       (x),
				.ctl     (ctl),
				.part_in ('0),
				.sum     (sum_a[k]),
				.part_q  (part_a[k])
			);
		end else begin : g_body
			fcc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tap_we  (tap_we[k]),
				.tap_d   (sample),
				.x       (x),
				.ctl     (ctl),
				.part_in (part_a[k-1]),
				.sum     (sum_a[k]),
				.part_q  (part_a[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= '0;
			load_pos_q  <= '0;
			flush_cnt_q <= '0;
		end else begin
			if (ref_acc) begin
				if (last) begin
					tap_count_q <= load_pos_q + TCNT_W'(room);
					load_pos_q  <= '0;
				end else begin
					// first beat of a new reference drops the old one
					if (load_pos_q == '0) begin
						tap_count_q <= '0;
					end
					if (room) begin
						load_pos_q <= load_pos_q + TCNT_W'(1);
					end
				end
			end
			if (dat_acc && last && (tap_count_q > TCNT_W'(1))) begin
				flush_cnt_q <= IDX_W'(tap_count_q - TCNT_W'(1));
			end else if (flush_step) begin
				flush_cnt_q <= flush_cnt_q - IDX_W'(1);
			end
		end
	end

	fcc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl.shift),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign value     = out_data.value;
	assign final_res = out_data.final_res;

endmodule

[design/fcc_checker.sv]
// Port-level checks of the full cross-correlation block and their bind.
module fcc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   func,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [fcc_pkg::VALUE_WIDTH-1:0] value,
	input logic                                   final_res
);
	import fcc_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(final_res))
		else $error("result beat changed while stalled");

	// every data beat leaves a result in the queue
	a_data_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func |=> out_valid)
		else $error("data beat gave no result");

	// input is never held back while the result queue is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result queue");

	// a result beat marked final is followed by a ready input side once drained
	a_final_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_res |=> in_ready || out_valid)
		else $error("block stuck after final result");

endmodule

bind full_cross_correlation fcc_checker u_fcc_checker (.*);
